// ----- hw/rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_UNICODE = 3'd3,
        MODE_DISCARD = 3'd4
    } t_mode;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
    localparam logic [3:0] ERR_UNTERM      = 4'd2;
    localparam logic [3:0] ERR_CONTROL     = 4'd3;
    localparam logic [3:0] ERR_ESC_CUT     = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC     = 4'd5;
    localparam logic [3:0] ERR_SHORT_UNI   = 4'd6;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd7;
    localparam logic [3:0] ERR_SURROGATE   = 4'd8;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;
    localparam logic [7:0] CTRL_TAB = 8'h09;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // one queued entry: up to three beats of the same kind
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] code;
        logic [1:0] last_idx;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

endpackage

// ----- hw/rtl/json_string_unescaper_utf8.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake          | beat
// input    | in        | i_valid / o_ready  | i_data_byte, i_end_of_input
// result   | out       | o_valid / i_ready  | o_kind, o_out_byte, o_error_code, o_last
//
// one input beat per cycle while the command queue has room
// each queued command leaves as one to three result beats, one per cycle while i_ready is high
// a three-byte utf-8 sequence holds the queue head until its last byte is accepted
// an input beat is registered in the command queue, then in the output register, before its first result beat
// synchronous active-low reset clears decoder state, queue pointers and output valid
module json_string_unescaper_utf8 #(
    parameter int P_QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_error_code,
    output logic       o_last
);

    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    jsu_pkg::t_cmd push_cmd;
    jsu_pkg::t_cmd head_cmd;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    jsu_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    a_single_beat_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != jsu_pkg::KIND_DATA) |-> o_last)
        else $error("close or error beat not marked last");

    a_status_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != jsu_pkg::KIND_DATA) |-> (o_out_byte == 8'd0))
        else $error("non-data beat carries a byte");

    a_error_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == jsu_pkg::KIND_ERROR) == (o_error_code != jsu_pkg::ERR_NONE)))
        else $error("error code disagrees with kind");

    a_utf8_continuation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_valid && o_kind == jsu_pkg::KIND_DATA
                                             && o_out_byte[7:6] == 2'b10))
        else $error("multi-byte sequence broken");

endmodule

// ----- hw/rtl/jsu_front.sv -----
`timescale 1ns / 1ps
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_input,
    input  logic          i_full,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_hex_cnt, n_hex_cnt;
    logic [15:0]    r_code, n_code;

    logic        accept;
    logic        is_hex;
    logic [3:0]  hex_digit;
    logic [15:0] code_next;
    logic        surrogate;
    logic        cmd_valid;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && cmd_valid;

    always_comb begin
        is_hex    = 1'b1;
        hex_digit = i_data_byte[3:0];
        case (i_data_byte) inside
            [8'h30:8'h39]: hex_digit = i_data_byte[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: hex_digit = {1'b0, i_data_byte[2:0]} + 4'd9;
            default: is_hex = 1'b0;
        endcase
    end

    assign code_next = {r_code[11:0], hex_digit};
    assign surrogate = (code_next[15:11] == 5'b11011);

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_code    = r_code;
        case (r_mode)
            jsu_pkg::MODE_IDLE: begin
                if (!i_end_of_input) begin
                    n_mode = (i_data_byte == jsu_pkg::CHAR_QUOTE) ? jsu_pkg::MODE_STRING
                                                                   : jsu_pkg::MODE_DISCARD;
                end
            end
            jsu_pkg::MODE_STRING: begin
                if (i_end_of_input || i_data_byte == jsu_pkg::CHAR_QUOTE) begin
                    n_mode = jsu_pkg::MODE_IDLE;
                end else if (i_data_byte == jsu_pkg::CHAR_BACKSLASH) begin
                    n_mode = jsu_pkg::MODE_ESCAPE;
                end else if (i_data_byte < jsu_pkg::CHAR_SPACE) begin
                    n_mode = jsu_pkg::MODE_DISCARD;
                end
            end
            jsu_pkg::MODE_ESCAPE: begin
                if (i_end_of_input) begin
                    n_mode = jsu_pkg::MODE_IDLE;
                end else begin
                    case (i_data_byte)
                        jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH,
                        jsu_pkg::CHAR_B, jsu_pkg::CHAR_F, jsu_pkg::CHAR_N,
                        jsu_pkg::CHAR_R, jsu_pkg::CHAR_T: n_mode = jsu_pkg::MODE_STRING;
                        jsu_pkg::CHAR_U: begin
                            n_mode    = jsu_pkg::MODE_UNICODE;
                            n_hex_cnt = 2'd0;
                            n_code    = 16'd0;
                        end
                        default: n_mode = jsu_pkg::MODE_DISCARD;
                    endcase
                end
            end
            jsu_pkg::MODE_UNICODE: begin
                if (i_end_of_input) begin
                    n_mode = jsu_pkg::MODE_IDLE;
                end else if (!is_hex) begin
                    n_mode = jsu_pkg::MODE_DISCARD;
                end else begin
                    n_code = code_next;
                    if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end else begin
                        n_hex_cnt = 2'd0;
                        n_mode    = surrogate ? jsu_pkg::MODE_DISCARD : jsu_pkg::MODE_STRING;
                    end
                end
            end
            default: begin
                if (i_end_of_input) begin
                    n_mode = jsu_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    // queued command
    always_comb begin
        cmd_valid = 1'b0;
        o_cmd     = '0;
        case (r_mode)
            jsu_pkg::MODE_IDLE: begin
                if (!i_end_of_input && i_data_byte != jsu_pkg::CHAR_QUOTE) begin
                    cmd_valid  = 1'b1;
                    o_cmd.kind = jsu_pkg::KIND_ERROR;
                    o_cmd.code = jsu_pkg::ERR_NO_QUOTE;
                end
            end
            jsu_pkg::MODE_STRING: begin
                cmd_valid = 1'b1;
                if (i_end_of_input) begin
                    o_cmd.kind = jsu_pkg::KIND_ERROR;
                    o_cmd.code = jsu_pkg::ERR_UNTERM;
                end else if (i_data_byte == jsu_pkg::CHAR_QUOTE) begin
                    o_cmd.kind = jsu_pkg::KIND_CLOSE;
                end else if (i_data_byte == jsu_pkg::CHAR_BACKSLASH) begin
                    cmd_valid = 1'b0;
                end else if (i_data_byte < jsu_pkg::CHAR_SPACE) begin
                    o_cmd.kind = jsu_pkg::KIND_ERROR;
                    o_cmd.code = jsu_pkg::ERR_CONTROL;
                end else begin
                    o_cmd.kind = jsu_pkg::KIND_DATA;
                    o_cmd.b0   = i_data_byte;
                end
            end
            jsu_pkg::MODE_ESCAPE: begin
                cmd_valid  = 1'b1;
                o_cmd.kind = jsu_pkg::KIND_DATA;
                if (i_end_of_input) begin
                    o_cmd.kind = jsu_pkg::KIND_ERROR;
                    o_cmd.code = jsu_pkg::ERR_ESC_CUT;
                end else begin
                    case (i_data_byte)
                        jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH,
                        jsu_pkg::CHAR_SLASH: o_cmd.b0 = i_data_byte;
                        jsu_pkg::CHAR_B:     o_cmd.b0 = jsu_pkg::CTRL_BS;
                        jsu_pkg::CHAR_F:     o_cmd.b0 = jsu_pkg::CTRL_FF;
                        jsu_pkg::CHAR_N:     o_cmd.b0 = jsu_pkg::CTRL_LF;
                        jsu_pkg::CHAR_R:     o_cmd.b0 = jsu_pkg::CTRL_CR;
                        jsu_pkg::CHAR_T:     o_cmd.b0 = jsu_pkg::CTRL_TAB;
                        jsu_pkg::CHAR_U:     cmd_valid = 1'b0;
                        default: begin
                            o_cmd.kind = jsu_pkg::KIND_ERROR;
                            o_cmd.code = jsu_pkg::ERR_BAD_ESC;
                        end
                    endcase
                end
            end
            jsu_pkg::MODE_UNICODE: begin
                if (i_end_of_input) begin
                    cmd_valid  = 1'b1;
                    o_cmd.kind = jsu_pkg::KIND_ERROR;
                    o_cmd.code = jsu_pkg::ERR_SHORT_UNI;
                end else if (!is_hex) begin
                    cmd_valid  = 1'b1;
                    o_cmd.kind = jsu_pkg::KIND_ERROR;
                    o_cmd.code = jsu_pkg::ERR_BAD_HEX;
                end else if (r_hex_cnt == 2'd3) begin
                    cmd_valid = 1'b1;
                    if (surrogate) begin
                        o_cmd.kind = jsu_pkg::KIND_ERROR;
                        o_cmd.code = jsu_pkg::ERR_SURROGATE;
                    end else if (code_next[15:7] == 9'd0) begin
                        o_cmd.b0 = code_next[7:0];
                    end else if (code_next[15:11] == 5'd0) begin
                        o_cmd.last_idx = 2'd1;
                        o_cmd.b0       = jsu_pkg::UTF8_LEAD2 | {3'd0, code_next[10:6]};
                        o_cmd.b1       = jsu_pkg::UTF8_CONT | {2'd0, code_next[5:0]};
                    end else begin
                        o_cmd.last_idx = 2'd2;
                        o_cmd.b0       = jsu_pkg::UTF8_LEAD3 | {4'd0, code_next[15:12]};
                        o_cmd.b1       = jsu_pkg::UTF8_CONT | {2'd0, code_next[11:6]};
                        o_cmd.b2       = jsu_pkg::UTF8_CONT | {2'd0, code_next[5:0]};
                    end
                end
            end
            default: begin
                cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_IDLE;
            r_hex_cnt <= 2'd0;
            r_code    <= 16'd0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_code    <= n_code;
        end
    end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
`timescale 1ns / 1ps
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output jsu_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/jsu_back.sv -----
`timescale 1ns / 1ps
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  jsu_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_out_byte,
    output logic [3:0]    o_error_code,
    output logic          o_last
);

    logic          r_valid;
    jsu_pkg::t_cmd r_cmd;
    logic [1:0]    r_idx;

    assign o_valid      = r_valid;
    assign o_kind       = r_cmd.kind;
    assign o_error_code = r_cmd.code;
    assign o_last       = (r_idx == r_cmd.last_idx);

    always_comb begin
        case (r_idx)
            2'd0:    o_out_byte = r_cmd.b0;
            2'd1:    o_out_byte = r_cmd.b1;
            default: o_out_byte = r_cmd.b2;
        endcase
    end

    assign o_pop = i_q_valid && (!r_valid || (i_ready && o_last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule
